/* hdl/cmsb_pkg.sv */
package cmsb_pkg;

    // default sizes of the presence map and entry capacity
    localparam int DEF_MAX_ROWS    = 16;
    localparam int DEF_MAX_COLS    = 16;
    localparam int DEF_MAX_ENTRIES = 32;

    // field widths
    localparam int COORD_W  = 4;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 6;
    localparam int TOTAL_W  = 6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // configuration reset values
    localparam logic [CFG_W-1:0] ROW_COUNT_RST    = 5'd16;
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RST = 5'd16;

    // result kinds
    localparam logic ITEM_ROW = 1'b0;
    localparam logic ITEM_COL = 1'b1;

    // input transaction
    typedef struct packed {
        logic               entry_valid;
        logic [COORD_W-1:0] entry_row;
        logic [COORD_W-1:0] entry_column;
        logic               final_entry;
    } entry_t;

    // result transaction
    typedef struct packed {
        logic               item_kind;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
        logic               diagonal_present;
        logic [TOTAL_W-1:0] total_entries;
        logic               dropped;
        logic               last;
    } result_t;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW_ITEM,
        ST_ROW_SCAN,
        ST_COL_SCAN
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic insert;
        logic walk_init;
        logic emit_row;
        logic row_step;
        logic col_init;
        logic col_step;
        logic emit_col;
        logic clear;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic load_ok;
        logic row_at_end;
        logic col_at_end;
        logic no_cols;
        logic hit;
        logic slot_last;
    } sts_t;

endpackage

/* hdl/coordinate_to_msr_sparsity_builder_unit.sv */
// coordinate to modified-sparse-row builder
//
// request channel (req_valid / req_stall / req_data): one coordinate per
// transaction, any order, repeats allowed. while no emission runs, a
// transaction is taken every cycle and marks its bit in the presence map.
// a transaction with final_entry set ends the set; req_stall then stays
// high until the whole structure has been handed to the response register.
// response channel (rsp_valid / rsp_stall / rsp_data): row items 0..R first,
// then the off-diagonal column indices in row-major order; last marks the end.
// the first row item is loaded in the row-item state that follows the final
// transaction, once the output register is free. the emission walks the map
// one cell per cycle in two passes, but holds while a result is due and the
// output register is full. a stalled response holds in the output register and
// the walk waits on it; the next request may be taken while the last response
// still waits. the user must write configuration (cfg_we / cfg_index /
// cfg_wdata) only while idle; the block does not enforce it. reset clears the
// map, the entry count and the drop flag at once, and sets both counts to 16.
module coordinate_to_msr_sparsity_builder_unit #(
    parameter int MAX_ROWS    = cmsb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = cmsb_pkg::DEF_MAX_COLS,
    parameter int MAX_ENTRIES = cmsb_pkg::DEF_MAX_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cmsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmsb_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  cmsb_pkg::entry_t               req_data,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output cmsb_pkg::result_t              rsp_data
);

    cmsb_pkg::cmd_t cmd;
    cmsb_pkg::sts_t sts;

    // sequencing
    cmsb_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .final_entry (req_data.final_entry),
        .req_stall   (req_stall),
        .sts         (sts),
        .cmd         (cmd)
    );

    // map, counters and output register
    cmsb_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_data  (req_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

endmodule

/* hdl/cmsb_ctrl.sv */
module cmsb_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            final_entry,
    output logic            req_stall,
    input  cmsb_pkg::sts_t  sts,
    output cmsb_pkg::cmd_t  cmd
);

    cmsb_pkg::state_t state_reg;
    cmsb_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cmsb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        unique case (state_reg)
            cmsb_pkg::ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.insert = 1'b1;
                    if (final_entry)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = cmsb_pkg::ST_ROW_ITEM;
                    end
                end
            end
            cmsb_pkg::ST_ROW_ITEM:
            begin
                if (sts.load_ok)
                begin
                    cmd.emit_row = 1'b1;
                    if (!sts.row_at_end)
                    begin
                        state_next = cmsb_pkg::ST_ROW_SCAN;
                    end
                    else if (sts.no_cols)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = cmsb_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.col_init = 1'b1;
                        state_next   = cmsb_pkg::ST_COL_SCAN;
                    end
                end
            end
            cmsb_pkg::ST_ROW_SCAN:
            begin
                cmd.row_step = 1'b1;
                if (sts.col_at_end)
                begin
                    state_next = cmsb_pkg::ST_ROW_ITEM;
                end
            end
            cmsb_pkg::ST_COL_SCAN:
            begin
                // hold on a hit while the output register is full
                if (!sts.hit || sts.load_ok)
                begin
                    cmd.col_step = 1'b1;
                    cmd.emit_col = sts.hit;
                    if (sts.hit && sts.slot_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = cmsb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = cmsb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/cmsb_datapath.sv */
module cmsb_datapath #(
    parameter int MAX_ROWS    = cmsb_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = cmsb_pkg::DEF_MAX_COLS,
    parameter int MAX_ENTRIES = cmsb_pkg::DEF_MAX_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [cmsb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmsb_pkg::CFG_W-1:0]     cfg_wdata,
    input  cmsb_pkg::entry_t               req_data,
    input  cmsb_pkg::cmd_t                 cmd,
    output cmsb_pkg::sts_t                 sts,
    input  logic                           rsp_stall,
    output logic                           rsp_valid,
    output cmsb_pkg::result_t              rsp_data
);

    localparam int RIDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIDX_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    logic [cmsb_pkg::CFG_W-1:0]          row_count_reg;
    logic [cmsb_pkg::CFG_W-1:0]          column_count_reg;
    logic [MAX_ROWS-1:0][MAX_COLS-1:0]   map_reg;
    logic [CNT_W-1:0]                    count_reg;
    logic                                drop_reg;
    logic [ROW_W-1:0]                    walk_row_reg;
    logic [CIDX_W-1:0]                   walk_col_reg;
    logic [CNT_W-1:0]                    offset_reg;
    logic [CNT_W-1:0]                    diag_cnt_reg;
    logic [CNT_W-1:0]                    slot_reg;
    logic                                rsp_valid_reg;
    cmsb_pkg::result_t                   rsp_data_reg;

    logic [ROW_W-1:0]  rows_used;
    logic [COL_W-1:0]  cols_used;
    logic [RIDX_W-1:0] ins_row;
    logic [CIDX_W-1:0] ins_col;
    logic              ins_in_range;
    logic              ins_bit;
    logic [RIDX_W-1:0] walk_ridx;
    logic              cur_bit;
    logic              on_diag;
    logic              row_diag;
    logic              load_ok;
    logic [CNT_W:0]    total_sum;

    // clamp the counts in use
    always_comb
    begin
        if (row_count_reg == '0)
        begin
            rows_used = ROW_W'(1);
        end
        else if (32'(row_count_reg) > MAX_ROWS)
        begin
            rows_used = ROW_W'(MAX_ROWS);
        end
        else
        begin
            rows_used = ROW_W'(row_count_reg);
        end

        if (column_count_reg == '0)
        begin
            cols_used = COL_W'(1);
        end
        else if (32'(column_count_reg) > MAX_COLS)
        begin
            cols_used = COL_W'(MAX_COLS);
        end
        else
        begin
            cols_used = COL_W'(column_count_reg);
        end
    end

    // incoming coordinate lookup
    assign ins_row      = RIDX_W'(req_data.entry_row);
    assign ins_col      = CIDX_W'(req_data.entry_column);
    assign ins_in_range = (32'(req_data.entry_row) < 32'(rows_used))
                       && (32'(req_data.entry_column) < 32'(cols_used));
    assign ins_bit      = map_reg[ins_row][ins_col];

    // walk cell lookup
    assign walk_ridx = walk_row_reg[RIDX_W-1:0];
    assign cur_bit   = map_reg[walk_ridx][walk_col_reg];
    assign on_diag   = (32'(walk_row_reg) == 32'(walk_col_reg));
    assign row_diag  = (32'(walk_row_reg) < 32'(rows_used))
                    && (32'(walk_row_reg) < 32'(cols_used))
                    && map_reg[walk_ridx][CIDX_W'(walk_row_reg)];

    assign load_ok   = !rsp_valid_reg || !rsp_stall;
    assign total_sum = {1'b0, offset_reg} + {1'b0, diag_cnt_reg};

    // status to controller
    always_comb
    begin
        sts.load_ok    = load_ok;
        sts.row_at_end = (walk_row_reg == rows_used);
        sts.col_at_end = (32'(walk_col_reg) + 32'd1 == 32'(cols_used));
        sts.no_cols    = (offset_reg == '0);
        sts.hit        = cur_bit && !on_diag;
        sts.slot_last  = (32'(slot_reg) + 32'd1 == 32'(offset_reg));
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= cmsb_pkg::ROW_COUNT_RST;
            column_count_reg <= cmsb_pkg::COLUMN_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cmsb_pkg::REG_ROW_COUNT:    row_count_reg    <= cfg_wdata;
                cmsb_pkg::REG_COLUMN_COUNT: column_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // presence map, distinct count and drop flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg   <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.clear)
        begin
            map_reg   <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else if (cmd.insert && req_data.entry_valid)
        begin
            if (!ins_in_range)
            begin
                drop_reg <= 1'b1;
            end
            else if (!ins_bit)
            begin
                if (32'(count_reg) >= MAX_ENTRIES)
                begin
                    drop_reg <= 1'b1;
                end
                else
                begin
                    map_reg[ins_row][ins_col] <= 1'b1;
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
        end
    end

    // walk counters and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_row_reg <= '0;
            walk_col_reg <= '0;
            offset_reg   <= '0;
            diag_cnt_reg <= '0;
            slot_reg     <= '0;
        end
        else if (cmd.walk_init)
        begin
            walk_row_reg <= '0;
            walk_col_reg <= '0;
            offset_reg   <= '0;
            diag_cnt_reg <= '0;
            slot_reg     <= '0;
        end
        else if (cmd.col_init)
        begin
            walk_row_reg <= '0;
            walk_col_reg <= '0;
        end
        else if (cmd.row_step || cmd.col_step)
        begin
            if (cmd.row_step && cur_bit)
            begin
                if (on_diag)
                begin
                    diag_cnt_reg <= diag_cnt_reg + CNT_W'(1);
                end
                else
                begin
                    offset_reg <= offset_reg + CNT_W'(1);
                end
            end
            if (cmd.emit_col)
            begin
                slot_reg <= slot_reg + CNT_W'(1);
            end
            if (sts.col_at_end)
            begin
                walk_col_reg <= '0;
                walk_row_reg <= walk_row_reg + ROW_W'(1);
            end
            else
            begin
                walk_col_reg <= walk_col_reg + CIDX_W'(1);
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.emit_row || cmd.emit_col)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.emit_row)
        begin
            rsp_data_reg.item_kind        <= cmsb_pkg::ITEM_ROW;
            rsp_data_reg.position         <= cmsb_pkg::POS_W'(walk_row_reg);
            rsp_data_reg.value            <= cmsb_pkg::VALUE_W'(offset_reg);
            rsp_data_reg.diagonal_present <= row_diag;
            rsp_data_reg.total_entries    <= sts.row_at_end
                                             ? cmsb_pkg::TOTAL_W'(total_sum) : '0;
            rsp_data_reg.dropped          <= drop_reg;
            rsp_data_reg.last             <= sts.row_at_end && sts.no_cols;
        end
        else if (cmd.emit_col)
        begin
            rsp_data_reg.item_kind        <= cmsb_pkg::ITEM_COL;
            rsp_data_reg.position         <= cmsb_pkg::POS_W'(slot_reg);
            rsp_data_reg.value            <= cmsb_pkg::VALUE_W'(walk_col_reg);
            rsp_data_reg.diagonal_present <= 1'b0;
            rsp_data_reg.total_entries    <= '0;
            rsp_data_reg.dropped          <= drop_reg;
            rsp_data_reg.last             <= sts.slot_last;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

/* hdl/cmsb_checker.sv */
module cmsb_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_stall,
    input cmsb_pkg::entry_t               req_data,
    input logic                           rsp_valid,
    input logic                           rsp_stall,
    input cmsb_pkg::result_t              rsp_data
);

    // a stalled response transaction holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
        else $error("stalled response changed");

    // a final transaction closes the request side
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall && req_data.final_entry |=> req_stall)
        else $error("request taken right after final entry");

    // new responses come only from an emission in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("response appeared while idle");

    // column items carry no diagonal flag and no total
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.item_kind == cmsb_pkg::ITEM_COL
        |-> rsp_data.total_entries == '0 && !rsp_data.diagonal_present)
        else $error("column item with row fields set");

    // a row item that ends the run has an empty column array
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.last && rsp_data.item_kind == cmsb_pkg::ITEM_ROW
        |-> rsp_data.value == '0)
        else $error("run ended on row item with columns pending");

endmodule

bind coordinate_to_msr_sparsity_builder_unit cmsb_checker u_cmsb_checker (.*);

/* sim/coordinate_to_msr_sparsity_builder_unit_tb.sv */
module coordinate_to_msr_sparsity_builder_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT    = 5000;
    localparam int RANDOM_ITEMS   = 246;

    // directed plan steps
    typedef enum logic {
        STEP_ENTRY,
        STEP_WRITE
    } plan_kind_t;

    typedef struct {
        plan_kind_t                       kind;
        logic [cmsb_pkg::CFG_IDX_W-1:0]   reg_index;
        logic [cmsb_pkg::CFG_W-1:0]       reg_value;
        cmsb_pkg::entry_t                 entry;
        bit                               typed;
        cmsb_pkg::result_t                want_last;
    } plan_row_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [cmsb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [cmsb_pkg::CFG_W-1:0]     cfg_wdata = '0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    cmsb_pkg::entry_t               req_data  = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    cmsb_pkg::result_t              rsp_data;

    // predictor state
    bit [cmsb_pkg::DEF_MAX_COLS-1:0] pmap [cmsb_pkg::DEF_MAX_ROWS];
    int                              held_positions;
    bit                              drop_seen;
    logic [cmsb_pkg::CFG_W-1:0]      rows_reg;
    logic [cmsb_pkg::CFG_W-1:0]      cols_reg;

    cmsb_pkg::result_t msr_expected [$];
    plan_row_t         plan [$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;
    bit                calm           = 1'b0;

    coordinate_to_msr_sparsity_builder_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    // clock
    always #4 clk = ~clk;

    // count register as the walk sees it
    function automatic int eff_count(logic [cmsb_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > cmsb_pkg::DEF_MAX_ROWS) ? cmsb_pkg::DEF_MAX_ROWS : int'(v);
    endfunction

    function automatic void clear_map();
        foreach (pmap[i])
            pmap[i] = '0;
        held_positions = 0;
        drop_seen      = 1'b0;
    endfunction

    // store one coordinate and, on the end mark, queue the whole msr stream
    function automatic void predict_msr(cmsb_pkg::entry_t e);
        int                nr;
        int                nc;
        int                dl;
        int                total;
        int                offset;
        int                slot;
        int                r;
        int                c;
        bit                is_diag;
        cmsb_pkg::result_t res;
        nr     = eff_count(rows_reg);
        nc     = eff_count(cols_reg);
        dl     = (nr < nc) ? nr : nc;
        total  = 0;
        offset = 0;
        slot   = 0;
        if (e.entry_valid)
        begin
            if (e.entry_row >= nr || e.entry_column >= nc)
                drop_seen = 1'b1;
            else if (!pmap[e.entry_row][e.entry_column])
            begin
                if (held_positions >= cmsb_pkg::DEF_MAX_ENTRIES)
                    drop_seen = 1'b1;
                else
                begin
                    pmap[e.entry_row][e.entry_column] = 1'b1;
                    held_positions++;
                end
            end
        end
        if (!e.final_entry)
            return;

        for (r = 0; r < nr; r++)
            for (c = 0; c < nc; c++)
                if (pmap[r][c])
                    total++;

        // row pointer items 0..nr
        for (r = 0; r <= nr; r++)
        begin
            res                  = '0;
            res.item_kind        = cmsb_pkg::ITEM_ROW;
            res.position         = cmsb_pkg::POS_W'(r);
            res.value            = cmsb_pkg::VALUE_W'(offset);
            res.dropped          = drop_seen;
            res.total_entries    = (r == nr) ? cmsb_pkg::TOTAL_W'(total) : '0;
            if (r < dl)
                res.diagonal_present = pmap[r][r];
            msr_expected.push_back(res);
            if (r < nr)
            begin
                for (c = 0; c < nc; c++)
                begin
                    is_diag = (r == c) && (r < dl);
                    if (pmap[r][c] && !is_diag)
                        offset++;
                end
            end
        end

        // off-diagonal column indices, row-major
        for (r = 0; r < nr; r++)
        begin
            for (c = 0; c < nc; c++)
            begin
                is_diag = (r == c) && (r < dl);
                if (pmap[r][c] && !is_diag)
                begin
                    res           = '0;
                    res.item_kind = cmsb_pkg::ITEM_COL;
                    res.position  = cmsb_pkg::POS_W'(slot);
                    res.value     = cmsb_pkg::VALUE_W'(c);
                    res.dropped   = drop_seen;
                    msr_expected.push_back(res);
                    slot++;
                end
            end
        end

        res      = msr_expected.pop_back();
        res.last = 1'b1;
        msr_expected.push_back(res);
        clear_map();
    endfunction

    function automatic cmsb_pkg::entry_t coord(int v, int r, int c, int f);
        cmsb_pkg::entry_t e;
        e.entry_valid  = (v != 0);
        e.entry_row    = cmsb_pkg::COORD_W'(r);
        e.entry_column = cmsb_pkg::COORD_W'(c);
        e.final_entry  = (f != 0);
        return e;
    endfunction

    // closing result of an emission run, typed by hand
    function automatic cmsb_pkg::result_t closing_result(logic kind, int pos, int val,
                                                         int total, int drop);
        cmsb_pkg::result_t res;
        res                  = '0;
        res.item_kind        = kind;
        res.position         = cmsb_pkg::POS_W'(pos);
        res.value            = cmsb_pkg::VALUE_W'(val);
        res.total_entries    = cmsb_pkg::TOTAL_W'(total);
        res.dropped          = (drop != 0);
        res.last             = 1'b1;
        return res;
    endfunction

    function automatic void plan_entry(int v, int r, int c, int f);
        plan_row_t p;
        p.kind      = STEP_ENTRY;
        p.reg_index = '0;
        p.reg_value = '0;
        p.entry     = coord(v, r, c, f);
        p.typed     = 1'b0;
        p.want_last = '0;
        plan.push_back(p);
    endfunction

    function automatic void plan_checked(int v, int r, int c, int f,
                                         cmsb_pkg::result_t want);
        plan_entry(v, r, c, f);
        plan[plan.size()-1].typed     = 1'b1;
        plan[plan.size()-1].want_last = want;
    endfunction

    function automatic void plan_write(logic [cmsb_pkg::CFG_IDX_W-1:0] idx, int val);
        plan_row_t p;
        p.kind      = STEP_WRITE;
        p.reg_index = idx;
        p.reg_value = cmsb_pkg::CFG_W'(val);
        p.entry     = '0;
        p.typed     = 1'b0;
        p.want_last = '0;
        plan.push_back(p);
    endfunction

    // random count, extremes and out-of-range values included
    function automatic logic [cmsb_pkg::CFG_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return cmsb_pkg::CFG_W'($urandom_range(17, 31));
            2:       return cmsb_pkg::CFG_W'(16);
            3:       return cmsb_pkg::CFG_W'(1);
            default: return cmsb_pkg::CFG_W'($urandom_range(1, 16));
        endcase
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    endtask

    // field-by-field compare against the oldest expectation
    task automatic check_result(cmsb_pkg::result_t got);
        cmsb_pkg::result_t want;
        if (msr_expected.size() == 0)
        begin
            report_mismatch("result with nothing pending", 32'(got), 0);
            return;
        end
        want = msr_expected.pop_front();
        if (got.item_kind !== want.item_kind)
            report_mismatch("item_kind", 32'(got.item_kind), 32'(want.item_kind));
        if (got.position !== want.position)
            report_mismatch("position", 32'(got.position), 32'(want.position));
        if (got.value !== want.value)
            report_mismatch("value", 32'(got.value), 32'(want.value));
        if (got.diagonal_present !== want.diagonal_present)
            report_mismatch("diagonal_present", 32'(got.diagonal_present),
                            32'(want.diagonal_present));
        if (got.total_entries !== want.total_entries)
            report_mismatch("total_entries", 32'(got.total_entries),
                            32'(want.total_entries));
        if (got.dropped !== want.dropped)
            report_mismatch("dropped", 32'(got.dropped), 32'(want.dropped));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // one request transaction, with a random gap in front
    task automatic send_entry(cmsb_pkg::entry_t e, bit typed, cmsb_pkg::result_t want_last);
        int gap;
        @(negedge clk);
        if (!calm && $urandom_range(0, 99) < 28)
        begin
            gap = $urandom_range(1, 3);
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= e;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predict_msr(e);
        if (typed)
        begin
            void'(msr_expected.pop_back());
            msr_expected.push_back(want_last);
        end
    endtask

    // sender pauses until every pending result has arrived
    task automatic settle_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (msr_expected.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_count_reg(logic [cmsb_pkg::CFG_IDX_W-1:0] idx,
                                   logic [cmsb_pkg::CFG_W-1:0] val);
        settle_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == cmsb_pkg::REG_ROW_COUNT)
            rows_reg = val;
        else
            cols_reg = val;
    endtask

    // response monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_result(rsp_data);
    end

    // receiver stalls
    always @(negedge clk)
    begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < 28);
    end

    // watchdog on cycles with no accepted transaction
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int               random_items;
        int               set_no;
        int               n;
        int               k;
        int               p;
        int               nr;
        int               nc;
        bit               counted;
        cmsb_pkg::entry_t e;
        cmsb_pkg::entry_t recent [$];

        rows_reg = cmsb_pkg::ROW_COUNT_RST;
        cols_reg = cmsb_pkg::COLUMN_COUNT_RST;
        clear_map();

        // reset
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed plan
        plan_checked(0, 9, 6, 1, closing_result(cmsb_pkg::ITEM_ROW, 16, 0, 0, 0));
        plan_entry(0, 15, 15, 0);
        plan_entry(1, 0, 0, 0);
        plan_checked(1, 15, 15, 1, closing_result(cmsb_pkg::ITEM_ROW, 16, 0, 2, 0));
        plan_entry(1, 0, 15, 0);
        plan_entry(1, 15, 0, 0);
        plan_entry(1, 0, 15, 0);
        plan_entry(1, 3, 7, 1);
        // 1x1 matrix, both coordinates out of range
        plan_write(cmsb_pkg::REG_ROW_COUNT, 1);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 1);
        plan_entry(1, 1, 0, 0);
        plan_entry(1, 0, 1, 0);
        plan_checked(1, 0, 0, 1, closing_result(cmsb_pkg::ITEM_ROW, 1, 0, 1, 1));
        // zero count acts as one, oversized count acts as sixteen
        plan_write(cmsb_pkg::REG_ROW_COUNT, 0);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 31);
        plan_entry(1, 0, 5, 0);
        plan_entry(1, 0, 0, 0);
        plan_checked(1, 0, 15, 1, closing_result(cmsb_pkg::ITEM_COL, 1, 15, 0, 0));
        // counts shrink in the middle of a set
        plan_write(cmsb_pkg::REG_ROW_COUNT, 16);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 16);
        plan_entry(1, 10, 12, 0);
        plan_entry(1, 2, 2, 0);
        plan_write(cmsb_pkg::REG_ROW_COUNT, 4);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 4);
        plan_checked(0, 0, 0, 1, closing_result(cmsb_pkg::ITEM_ROW, 4, 0, 1, 0));
        // tall single column
        plan_write(cmsb_pkg::REG_ROW_COUNT, 16);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 1);
        plan_entry(1, 5, 0, 0);
        plan_entry(1, 0, 0, 0);
        plan_entry(1, 15, 0, 0);
        plan_entry(1, 7, 3, 1);
        // wide, two rows
        plan_write(cmsb_pkg::REG_ROW_COUNT, 2);
        plan_write(cmsb_pkg::REG_COLUMN_COUNT, 16);
        plan_entry(1, 1, 1, 0);
        plan_entry(1, 1, 9, 0);
        plan_entry(1, 2, 9, 1);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_WRITE)
                write_count_reg(plan[i].reg_index, plan[i].reg_value);
            else
                send_entry(plan[i].entry, plan[i].typed, plan[i].want_last);
        end

        // random sets
        random_items = 0;
        set_no       = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_no++;
            calm = (set_no >= 8 && set_no < 14);
            if (set_no == 5)
                settle_idle();
            p = $urandom_range(0, 99);
            recent.delete();
            if (p < 8)
            begin
                // capacity set on the full map
                write_count_reg(cmsb_pkg::REG_ROW_COUNT, cmsb_pkg::CFG_W'(16));
                write_count_reg(cmsb_pkg::REG_COLUMN_COUNT, cmsb_pkg::CFG_W'(16));
                for (k = 0; k < 45; k++)
                begin
                    e = coord(1, $urandom_range(0, 15), $urandom_range(0, 15),
                              int'(k == 44));
                    send_entry(e, 1'b0, '0);
                    random_items++;
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < 40)
                    write_count_reg(cmsb_pkg::REG_ROW_COUNT, pick_count());
                if ($urandom_range(0, 99) < 40)
                    write_count_reg(cmsb_pkg::REG_COLUMN_COUNT, pick_count());
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++)
                begin
                    // counts may change inside a set now and then
                    if (k == n / 2 && $urandom_range(0, 99) < 10)
                        write_count_reg($urandom_range(0, 1) ? cmsb_pkg::REG_ROW_COUNT
                                                             : cmsb_pkg::REG_COLUMN_COUNT,
                                        pick_count());
                    nr = eff_count(rows_reg);
                    nc = eff_count(cols_reg);
                    p  = $urandom_range(0, 99);
                    counted = 1'b1;
                    if (k == n - 1)
                    begin
                        if (p < 80)
                            e = coord(1, $urandom_range(0, nr - 1),
                                      $urandom_range(0, nc - 1), 1);
                        else
                            e = coord(0, $urandom_range(0, 15), $urandom_range(0, 15), 1);
                    end
                    else if (p < 70 || (p < 80 && recent.size() == 0))
                        e = coord(1, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1), 0);
                    else if (p < 80)
                        e = recent[$urandom_range(0, recent.size() - 1)];
                    else if (p < 90)
                        e = coord(1, $urandom_range(0, 15), $urandom_range(0, 15), 0);
                    else
                    begin
                        e = coord(0, $urandom_range(0, 15), $urandom_range(0, 15), 0);
                        counted = 1'b0;
                    end
                    if (e.entry_valid && !e.final_entry)
                        recent.push_back(e);
                    send_entry(e, 1'b0, '0);
                    if (counted)
                        random_items++;
                end
            end
        end

        // drain and finish
        calm = 1'b0;
        settle_idle();
        repeat (20) @(negedge clk);
        if (mismatch_count == 0 && msr_expected.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
